/* hw/rtl/fpr_pkg.sv */
// ----------------------------------------------------------------------------
// fpr_pkg: shared types and constants of the file push receiver
// Holds the phase and error codes, link request and header type codes,
// and the classified beat that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package fpr_pkg;

	// Field widths of the link items.
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned LEN_W   = 25;
	localparam int unsigned IN_W    = 160;
	localparam int unsigned OUT_W   = 104;

	// Reset values of the configuration registers.
	localparam logic [WORD_W-1:0] RESET_MAGIC  = 32'h5455_5452;
	localparam logic [LEN_W-1:0]  BUFFER_BYTES = 25'h100_0000;

	// Configuration register indexes.
	localparam logic CFG_MAGIC     = 1'b0;
	localparam logic CFG_MAX_CHUNK = 1'b1;

	// Link request kinds.
	localparam logic [1:0] REQ_HEADER = 2'd1;
	localparam logic [1:0] REQ_DATA   = 2'd2;

	// Header type codes.
	localparam logic [WORD_W-1:0] HDR_NAME  = 32'd1;
	localparam logic [WORD_W-1:0] HDR_RANGE = 32'd2;

	typedef enum logic [1:0] {
		PH_CONNECT = 2'd0,
		PH_NAME    = 2'd1,
		PH_RANGE   = 2'd2,
		PH_DATA    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE       = 3'd0,
		ERR_NAME       = 3'd1,
		ERR_RANGE_HDR  = 3'd2,
		ERR_ORDER      = 3'd3,
		ERR_LENGTH     = 3'd4,
		ERR_DISCONNECT = 3'd5
	} err_t;

	// One link event after classification by the front end.
	typedef struct packed {
		logic [1:0]        req_type;
		logic              link_up;
		logic              name_ok;
		logic              range_ok;
		logic              span_ok;
		logic              is_empty;
		logic [WORD_W-1:0] range_start;
		logic [WORD_W-1:0] range_end;
		logic [LEN_W-1:0]  span;
		logic [LEN_W-1:0]  payload_bytes;
		logic              ack_ok;
	} cls_item_t;

endpackage

/* hw/rtl/fpr_front.sv */
// ----------------------------------------------------------------------------
// fpr_front: input classification
// Holds the configuration registers, unpacks each input beat and checks the
// header magic, type code and range span against the chunk limit.
// ----------------------------------------------------------------------------
module fpr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [fpr_pkg::WORD_W-1:0] cfg_data,
	input  logic [fpr_pkg::IN_W-1:0]   beat_data,
	output fpr_pkg::cls_item_t         item
);
	import fpr_pkg::*;

	logic [WORD_W-1:0] magic_q;
	logic [LEN_W-1:0]  max_chunk_q;
	logic [LEN_W-1:0]  limit;

	logic [1:0]        req_type;
	logic              link_up;
	logic              header_whole;
	logic [WORD_W-1:0] magic;
	logic [WORD_W-1:0] type_code;
	logic [WORD_W-1:0] range_start;
	logic [WORD_W-1:0] range_end;
	logic [LEN_W-1:0]  payload_bytes;
	logic              ack_accepted;
	logic [WORD_W-1:0] diff;
	logic              hdr_base_ok;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q     <= RESET_MAGIC;
			max_chunk_q <= BUFFER_BYTES;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAGIC:     magic_q     <= cfg_data;
				CFG_MAX_CHUNK: max_chunk_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// The chunk limit never exceeds the receive buffer.
	assign limit = (max_chunk_q > BUFFER_BYTES) ? BUFFER_BYTES : max_chunk_q;

	// Unpack the beat, lowest field first.
	assign req_type      = beat_data[1:0];
	assign link_up       = beat_data[2];
	assign header_whole  = beat_data[3];
	assign magic         = beat_data[35:4];
	assign type_code     = beat_data[67:36];
	assign range_start   = beat_data[99:68];
	assign range_end     = beat_data[131:100];
	assign payload_bytes = beat_data[156:132];
	assign ack_accepted  = beat_data[157];

	// Header and range checks that do not depend on the receive state.
	assign diff        = range_end - range_start;
	assign hdr_base_ok = header_whole && (magic == magic_q);

	always_comb begin
		item.req_type      = req_type;
		item.link_up       = link_up;
		item.name_ok       = hdr_base_ok && (type_code == HDR_NAME);
		item.range_ok      = hdr_base_ok && (type_code == HDR_RANGE);
		item.span_ok       = (range_end >= range_start) &&
		                     (diff <= {{(WORD_W-LEN_W){1'b0}}, limit});
		item.is_empty      = (range_end == range_start);
		item.range_start   = range_start;
		item.range_end     = range_end;
		item.span          = diff[LEN_W-1:0];
		item.payload_bytes = payload_bytes;
		item.ack_ok        = ack_accepted;
	end

endmodule

/* hw/rtl/fpr_queue.sv */
// ----------------------------------------------------------------------------
// fpr_queue: classified beat queue
// A short register FIFO that lets the front end and the back end stall
// independently; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module fpr_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  fpr_pkg::cls_item_t push_item,
	output logic               pop_valid,
	input  logic               pop_ready,
	output fpr_pkg::cls_item_t pop_item
);
	import fpr_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cls_item_t        slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_item   = slot_q[rd_ptr_q];

	// Pointer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots carry payload only.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/fpr_back.sv */
// ----------------------------------------------------------------------------
// fpr_back: receive state machine
// Carries out one classified beat per cycle, while the output register is free or
// being taken, against the receive phase and file state; the result waits there until taken.
// ----------------------------------------------------------------------------
module fpr_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     item_valid,
	output logic                     item_ready,
	input  fpr_pkg::cls_item_t       item,
	output logic                     res_valid,
	input  logic                     res_ready,
	output logic [fpr_pkg::OUT_W-1:0] res_data
);
	import fpr_pkg::*;

	phase_t            phase_q;
	phase_t            phase_d;
	logic              file_open_q;
	logic              file_open_d;
	logic [WORD_W-1:0] file_pos_q;
	logic [WORD_W-1:0] file_pos_d;
	logic [WORD_W-1:0] pend_start_q;
	logic [WORD_W-1:0] pend_start_d;
	logic [LEN_W-1:0]  pend_len_q;
	logic [LEN_W-1:0]  pend_len_d;

	logic              res_valid_q;
	logic [OUT_W-1:0]  res_data_q;
	logic [OUT_W-1:0]  res_d;

	logic [1:0]        acks;
	logic              opened;
	logic [WORD_W-1:0] nlen;
	logic [LEN_W-1:0]  wlen;
	logic [WORD_W-1:0] woff;
	logic              saved;
	logic              aborted;
	err_t              err;

	logic              fire;
	logic              link_lost;
	logic              hdr_req;
	logic              data_req;
	logic              order_ok;

	assign item_ready = !res_valid_q || res_ready;
	assign fire       = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res_data   = res_data_q;

	// Shared decode of the current beat.
	assign link_lost = (phase_q != PH_CONNECT) && !item.link_up;
	assign hdr_req   = (item.req_type == REQ_HEADER);
	assign data_req  = (item.req_type == REQ_DATA) && (item.payload_bytes != '0);
	assign order_ok  = (item.range_start == file_pos_q) && item.span_ok;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (link_lost) begin
			phase_d = PH_CONNECT;
		end else begin
			case (phase_q)
				PH_CONNECT: begin
					if (item.link_up) phase_d = PH_NAME;
				end
				PH_NAME: begin
					if (hdr_req && item.name_ok) begin
						phase_d = item.ack_ok ? PH_RANGE : PH_CONNECT;
					end
				end
				PH_RANGE: begin
					if (hdr_req) begin
						if (!item.range_ok || !order_ok) begin
							phase_d = PH_NAME;
						end else if (!item.ack_ok) begin
							phase_d = PH_CONNECT;
						end else begin
							phase_d = item.is_empty ? PH_NAME : PH_DATA;
						end
					end
				end
				PH_DATA: begin
					if (data_req) begin
						if (item.payload_bytes != pend_len_q) begin
							phase_d = PH_NAME;
						end else begin
							phase_d = item.ack_ok ? PH_RANGE : PH_CONNECT;
						end
					end
				end
				default: phase_d = PH_CONNECT;
			endcase
		end
	end

	// Result fields and file state updates.
	always_comb begin
		acks         = 2'd0;
		opened       = 1'b0;
		nlen         = '0;
		wlen         = '0;
		woff         = '0;
		saved        = 1'b0;
		aborted      = 1'b0;
		err          = ERR_NONE;
		file_open_d  = file_open_q;
		file_pos_d   = file_pos_q;
		pend_start_d = pend_start_q;
		pend_len_d   = pend_len_q;
		if (link_lost) begin
			err = ERR_DISCONNECT;
		end else begin
			// A file still open on return to connect or name is aborted.
			if ((phase_q == PH_CONNECT || phase_q == PH_NAME) && file_open_q) begin
				aborted     = 1'b1;
				file_open_d = 1'b0;
			end
			case (phase_q)
				PH_NAME: begin
					if (hdr_req) begin
						if (!item.name_ok) begin
							err = ERR_NAME;
						end else if (!item.ack_ok) begin
							err = ERR_DISCONNECT;
						end else begin
							acks        = 2'd2;
							opened      = 1'b1;
							nlen        = item.range_end;
							file_pos_d  = '0;
							file_open_d = 1'b1;
						end
					end
				end
				PH_RANGE: begin
					if (hdr_req) begin
						if (!item.range_ok) begin
							err = ERR_RANGE_HDR;
						end else if (!order_ok) begin
							err = ERR_ORDER;
						end else if (!item.ack_ok) begin
							err = ERR_DISCONNECT;
						end else begin
							acks = 2'd1;
							if (item.is_empty) begin
								saved       = 1'b1;
								file_open_d = 1'b0;
							end else begin
								pend_start_d = item.range_start;
								pend_len_d   = item.span;
							end
						end
					end
				end
				PH_DATA: begin
					if (data_req) begin
						if (item.payload_bytes != pend_len_q) begin
							err = ERR_LENGTH;
						end else if (!item.ack_ok) begin
							err = ERR_DISCONNECT;
						end else begin
							acks       = 2'd1;
							wlen       = pend_len_q;
							woff       = pend_start_q;
							file_pos_d = file_pos_q + {{(WORD_W-LEN_W){1'b0}}, pend_len_q};
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Result packing, lowest field first.
	assign res_d = {5'd0, phase_d, err, aborted, saved, woff, wlen, nlen, opened, acks};

	// Control state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_CONNECT;
			file_open_q  <= 1'b0;
			file_pos_q   <= '0;
			pend_start_q <= '0;
			pend_len_q   <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (fire) begin
				phase_q      <= phase_d;
				file_open_q  <= file_open_d;
				file_pos_q   <= file_pos_d;
				pend_start_q <= pend_start_d;
				pend_len_q   <= pend_len_d;
				res_valid_q  <= 1'b1;
			end else if (res_ready) begin
				res_valid_q  <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (fire) begin
			res_data_q <= res_d;
		end
	end

endmodule

/* hw/rtl/file_push_receiver_fsm.sv */
// An accepted beat waits in a queue slot until the back end takes it and registers its result
// in the output register that drives the master side. Throughput: one beat per cycle while
// the output register is free or being taken; the back-end state machine settles one event
// per cycle. The beat queue absorbs a stalled output register for QUEUE_DEPTH beats.
// Reset: arst_n clears the phase to connect, the file state to zero, the beat queue and the
// output valid; the magic word returns to 0x54555452 and the chunk limit to 0x1000000.
// ----------------------------------------------------------------------------
// file_push_receiver_fsm: receive side of a host-to-device file push
// Front end classifies link events, a short queue decouples it from the
// back-end state machine that issues acks, opens, writes and closes.
// ----------------------------------------------------------------------------
module file_push_receiver_fsm #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Configuration write port.
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [fpr_pkg::WORD_W-1:0]  cfg_data,
	// Input link events.
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// tdata from bit 0: req_type[2], link_up, header_whole, magic[32], type_code[32],
	// range_start[32], range_end[32], payload_bytes[25], ack_accepted, zero fill
	input  logic [fpr_pkg::IN_W-1:0]    s_axis_tdata,
	// Result items.
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// tdata from bit 0: acks_sent[2], open_file, name_length[32], write_length[25],
	// write_offset[32], file_saved, file_aborted, error_code[3], phase[2], zero fill
	output logic [fpr_pkg::OUT_W-1:0]   m_axis_tdata
);
	import fpr_pkg::*;

	cls_item_t front_item;
	cls_item_t back_item;
	logic      back_valid;
	logic      back_ready;

	fpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.beat_data (s_axis_tdata),
		.item      (front_item)
	);

	fpr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	fpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (back_valid),
		.item_ready (back_ready),
		.item       (back_item),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_data   (m_axis_tdata)
	);

	// Opening a file always moves on to the range phase with two acks.
	a_open_to_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |->
			m_axis_tdata[98:97] == PH_RANGE && m_axis_tdata[1:0] == 2'd2)
		else $error("file open without range phase and two acks");

	// A write is always acknowledged once and returns to the range phase.
	a_write_acked: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[59:35] != '0 |->
			m_axis_tdata[1:0] == 2'd1 && m_axis_tdata[98:97] == PH_RANGE)
		else $error("write without single ack or range phase");

	// A saved file closes back to the name phase.
	a_saved_to_name: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[92] |->
			m_axis_tdata[98:97] == PH_NAME && m_axis_tdata[1:0] == 2'd1)
		else $error("saved file not back in name phase");

	// A disconnect sends no ack and lands in the connect phase.
	a_disconnect: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[96:94] == ERR_DISCONNECT |->
			m_axis_tdata[98:97] == PH_CONNECT && m_axis_tdata[1:0] == 2'd0)
		else $error("disconnect result outside connect phase");

endmodule

/* sim/fpr_push_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fpr_push_checker: result predictor and comparator for the file push receiver
// Watches the configuration port and both streams. Each accepted link event
// is run through a cycle-free model of the receiver state machine. Each result
// beat is compared field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
module fpr_push_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [fpr_pkg::WORD_W-1:0] cfg_data,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	// tdata from bit 0: req_type[2], link_up, header_whole, magic[32], type_code[32],
	// range_start[32], range_end[32], payload_bytes[25], ack_accepted, zero fill
	input  logic [fpr_pkg::IN_W-1:0]   s_axis_tdata,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// tdata from bit 0: acks_sent[2], open_file, name_length[32], write_length[25],
	// write_offset[32], file_saved, file_aborted, error_code[3], phase[2], zero fill
	input  logic [fpr_pkg::OUT_W-1:0]  m_axis_tdata,
	output int unsigned                fail_count,
	output int unsigned                pending,
	output int unsigned                result_count,
	output int unsigned                write_count,
	output int unsigned                save_count,
	output int unsigned                abort_count,
	output int unsigned                error_count
);
	import fpr_pkg::*;

	// One link event, highest field first.
	typedef struct packed {
		logic [1:0]        fill;
		logic              ack_accepted;
		logic [LEN_W-1:0]  payload_bytes;
		logic [WORD_W-1:0] range_end;
		logic [WORD_W-1:0] range_start;
		logic [WORD_W-1:0] type_code;
		logic [WORD_W-1:0] magic;
		logic              header_whole;
		logic              link_up;
		logic [1:0]        req_type;
	} link_evt_t;

	// One result beat, highest field first.
	typedef struct packed {
		logic [4:0]        fill;
		phase_t            phase;
		err_t              error_code;
		logic              file_aborted;
		logic              file_saved;
		logic [WORD_W-1:0] write_offset;
		logic [LEN_W-1:0]  write_length;
		logic [WORD_W-1:0] name_length;
		logic              open_file;
		logic [1:0]        acks_sent;
	} outcome_t;

	// Shadow configuration and receiver state.
	logic [WORD_W-1:0] magic_cfg;
	logic [LEN_W-1:0]  chunk_cfg;
	phase_t            ph;
	logic              file_open;
	logic [WORD_W-1:0] position;
	logic [WORD_W-1:0] pend_start;
	logic [LEN_W-1:0]  pend_len;

	outcome_t outcome_q[$];

	int unsigned fails_seen = 0;
	int unsigned waiting = 0;
	int unsigned results_seen = 0;
	int unsigned writes_seen = 0;
	int unsigned saves_seen = 0;
	int unsigned aborts_seen = 0;
	int unsigned errors_seen = 0;

	assign fail_count   = fails_seen;
	assign pending      = waiting;
	assign result_count = results_seen;
	assign write_count  = writes_seen;
	assign save_count   = saves_seen;
	assign abort_count  = aborts_seen;
	assign error_count  = errors_seen;

	function automatic logic header_good(input link_evt_t ev, input logic [WORD_W-1:0] kind);
		return ev.header_whole && ev.magic == magic_cfg && ev.type_code == kind;
	endfunction

	// Advances the shadow state by one link event and returns what the block reports.
	function automatic outcome_t next_push_outcome(input link_evt_t ev);
		outcome_t          r;
		logic [WORD_W-1:0] cap;
		logic [WORD_W-1:0] span;
		r = '0;
		cap = (chunk_cfg > BUFFER_BYTES) ? WORD_W'(BUFFER_BYTES) : WORD_W'(chunk_cfg);
		span = ev.range_end - ev.range_start;
		if (ph != PH_CONNECT && !ev.link_up) begin
			ph = PH_CONNECT;
			r.error_code = ERR_DISCONNECT;
		end else begin
			// A file left open when the connect or name phase comes back around is aborted first.
			if ((ph == PH_CONNECT || ph == PH_NAME) && file_open) begin
				r.file_aborted = 1'b1;
				file_open = 1'b0;
			end
			case (ph)
				PH_CONNECT: begin
					if (ev.link_up)
						ph = PH_NAME;
				end
				PH_NAME: begin
					if (ev.req_type == REQ_HEADER) begin
						if (!header_good(ev, HDR_NAME)) begin
							r.error_code = ERR_NAME;
						end else if (!ev.ack_accepted) begin
							ph = PH_CONNECT;
							r.error_code = ERR_DISCONNECT;
						end else begin
							r.acks_sent = 2'd2;
							r.open_file = 1'b1;
							r.name_length = ev.range_end;
							position = '0;
							file_open = 1'b1;
							ph = PH_RANGE;
						end
					end
				end
				PH_RANGE: begin
					if (ev.req_type == REQ_HEADER) begin
						if (!header_good(ev, HDR_RANGE)) begin
							r.error_code = ERR_RANGE_HDR;
							ph = PH_NAME;
						end else if (ev.range_start != position ||
								ev.range_end < ev.range_start || span > cap) begin
							r.error_code = ERR_ORDER;
							ph = PH_NAME;
						end else if (!ev.ack_accepted) begin
							ph = PH_CONNECT;
							r.error_code = ERR_DISCONNECT;
						end else begin
							r.acks_sent = 2'd1;
							if (span == 0) begin
								r.file_saved = 1'b1;
								file_open = 1'b0;
								ph = PH_NAME;
							end else begin
								pend_start = ev.range_start;
								pend_len = span[LEN_W-1:0];
								ph = PH_DATA;
							end
						end
					end
				end
				PH_DATA: begin
					if (ev.req_type == REQ_DATA && ev.payload_bytes != 0) begin
						if (ev.payload_bytes != pend_len) begin
							r.error_code = ERR_LENGTH;
							ph = PH_NAME;
						end else if (!ev.ack_accepted) begin
							ph = PH_CONNECT;
							r.error_code = ERR_DISCONNECT;
						end else begin
							r.acks_sent = 2'd1;
							r.write_length = pend_len;
							r.write_offset = pend_start;
							position = position + {{(WORD_W-LEN_W){1'b0}}, pend_len};
							ph = PH_RANGE;
						end
					end
				end
				default: ;
			endcase
		end
		r.phase = ph;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [WORD_W-1:0] want, got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
			fails_seen++;
		end
	endtask

	task automatic match_result(input outcome_t got);
		outcome_t want;
		if (outcome_q.size() == 0) begin
			$error("result beat arrived with no link event waiting for it");
			fails_seen++;
			return;
		end
		want = outcome_q.pop_front();
		check_field("acks_sent", want.acks_sent, got.acks_sent);
		check_field("open_file", want.open_file, got.open_file);
		check_field("name_length", want.name_length, got.name_length);
		check_field("write_length", want.write_length, got.write_length);
		check_field("write_offset", want.write_offset, got.write_offset);
		check_field("file_saved", want.file_saved, got.file_saved);
		check_field("file_aborted", want.file_aborted, got.file_aborted);
		check_field("error_code", want.error_code, got.error_code);
		check_field("phase", want.phase, got.phase);
		results_seen++;
		if (want.write_length != 0)
			writes_seen++;
		if (want.file_saved)
			saves_seen++;
		if (want.file_aborted)
			aborts_seen++;
		if (want.error_code != ERR_NONE)
			errors_seen++;
	endtask

	// Results are matched before new events are queued, so a beat can never
	// pair with an event accepted at the same edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_cfg = RESET_MAGIC;
			chunk_cfg = BUFFER_BYTES;
			ph = PH_CONNECT;
			file_open = 1'b0;
			position = '0;
			pend_start = '0;
			pend_len = '0;
			outcome_q.delete();
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_MAGIC)
					magic_cfg = cfg_data;
				else
					chunk_cfg = cfg_data[LEN_W-1:0];
			end
			if (m_axis_tvalid && m_axis_tready)
				match_result(outcome_t'(m_axis_tdata));
			if (s_axis_tvalid && s_axis_tready)
				outcome_q.push_back(next_push_outcome(link_evt_t'(s_axis_tdata)));
		end
		waiting = outcome_q.size();
	end

endmodule

/* sim/tb_file_push_receiver_fsm.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_file_push_receiver_fsm: stimulus and verdict for the file push receiver
// Drives a directed pass over the phase and error cases, a file that fills the
// whole 32-bit offset space, and random push sessions under several register
// settings with random idling on both streams and a long output stall.
// ----------------------------------------------------------------------------
module tb_file_push_receiver_fsm;
	import fpr_pkg::*;

	localparam int unsigned STALL_LIMIT  = 5000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned SETTLE_TICKS = 4;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam logic [1:0]  REQ_IDLE     = 2'd0;

	// One link event, highest field first.
	typedef struct packed {
		logic [1:0]        fill;
		logic              ack_accepted;
		logic [LEN_W-1:0]  payload_bytes;
		logic [WORD_W-1:0] range_end;
		logic [WORD_W-1:0] range_start;
		logic [WORD_W-1:0] type_code;
		logic [WORD_W-1:0] magic;
		logic              header_whole;
		logic              link_up;
		logic [1:0]        req_type;
	} link_evt_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic               cfg_index = CFG_MAGIC;
	logic [WORD_W-1:0]  cfg_data = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [OUT_W-1:0]   m_axis_tdata;

	int unsigned fails, pending, n_results, n_writes, n_saves, n_aborts, n_errors;

	logic              gaps_on = 1'b1;
	logic              hold_req = 1'b0;
	int unsigned       events_sent = 0;
	int unsigned       settings = 1;
	int unsigned       stall_cycles = 0;
	logic [WORD_W-1:0] cur_magic = RESET_MAGIC;
	logic [WORD_W-1:0] cur_cap = WORD_W'(BUFFER_BYTES);

	initial begin
		forever #4 clk = ~clk;
	end

	file_push_receiver_fsm dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	fpr_push_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fails),
		.pending       (pending),
		.result_count  (n_results),
		.write_count   (n_writes),
		.save_count    (n_saves),
		.abort_count   (n_aborts),
		.error_count   (n_errors)
	);

	// Watchdog: ends the run when no beat moves on either stream for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
			$display("status: fail");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Result side: random back-pressure, or a long hold-off on request.
	initial begin : result_sink
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= !gaps_on || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Event builders. Fields that the current phase does not look at stay random.
	function automatic link_evt_t noise_evt();
		link_evt_t ev;
		ev = {$urandom, $urandom, $urandom, $urandom, $urandom};
		ev.fill = '0;
		ev.req_type = 2'($urandom_range(0, 2));
		ev.payload_bytes = LEN_W'($urandom_range(0, BUFFER_BYTES));
		return ev;
	endfunction

	function automatic link_evt_t poll_evt();
		link_evt_t ev;
		ev = noise_evt();
		ev.req_type = REQ_IDLE;
		ev.link_up = 1'b1;
		return ev;
	endfunction

	function automatic link_evt_t link_drop_evt();
		link_evt_t ev;
		ev = noise_evt();
		ev.link_up = 1'b0;
		return ev;
	endfunction

	function automatic link_evt_t header_evt(input logic [WORD_W-1:0] kind, rs, re);
		link_evt_t ev;
		ev = noise_evt();
		ev.req_type = REQ_HEADER;
		ev.link_up = 1'b1;
		ev.header_whole = 1'b1;
		ev.magic = cur_magic;
		ev.type_code = kind;
		ev.range_start = rs;
		ev.range_end = re;
		ev.ack_accepted = 1'b1;
		return ev;
	endfunction

	function automatic link_evt_t data_evt(input logic [LEN_W-1:0] nbytes);
		link_evt_t ev;
		ev = noise_evt();
		ev.req_type = REQ_DATA;
		ev.link_up = 1'b1;
		ev.payload_bytes = nbytes;
		ev.ack_accepted = 1'b1;
		return ev;
	endfunction

	// An item of the wrong kind for the data phase, or an empty payload.
	function automatic link_evt_t stray_evt();
		link_evt_t ev;
		ev = noise_evt();
		ev.link_up = 1'b1;
		if ($urandom_range(0, 1)) begin
			ev.req_type = REQ_HEADER;
		end else begin
			ev.req_type = REQ_DATA;
			ev.payload_bytes = '0;
		end
		return ev;
	endfunction

	function automatic link_evt_t spoil_header(input link_evt_t ev);
		case ($urandom_range(0, 5))
			0: ev.magic = ev.magic ^ (32'd1 << $urandom_range(0, 31));
			1: ev.header_whole = 1'b0;
			2: ev.type_code = ev.type_code ^ (32'd1 << $urandom_range(0, 31));
			3: ev.ack_accepted = 1'b0;
			4: ev.link_up = 1'b0;
			default: ev.req_type = $urandom_range(0, 1) ? REQ_IDLE : REQ_DATA;
		endcase
		return ev;
	endfunction

	function automatic logic [WORD_W-1:0] pick_len(input logic [WORD_W-1:0] top_len);
		case ($urandom_range(0, 9))
			0: return top_len;
			1: return $urandom_range(1, top_len);
			default: return $urandom_range(1, (top_len < 64) ? top_len : 64);
		endcase
	endfunction

	// Offers one beat and returns at the edge that accepts it. Valid stays high
	// so the next beat can follow back to back.
	task automatic push_event(input link_evt_t ev);
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 25) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ev;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		events_sent++;
	endtask

	// Stops sending and waits until every predicted result has come back.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic configure(input logic [WORD_W-1:0] magic_val, chunk_val);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MAGIC;
		cfg_data <= magic_val;
		@(posedge clk);
		cfg_index <= CFG_MAX_CHUNK;
		cfg_data <= chunk_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_magic = magic_val;
		cur_cap = (chunk_val[LEN_W-1:0] > BUFFER_BYTES) ? WORD_W'(BUFFER_BYTES)
			: WORD_W'(chunk_val[LEN_W-1:0]);
		settings++;
	endtask

	// Walks every phase and each error and fallback path at least once.
	task automatic run_directed();
		link_evt_t ev;
		push_event(link_drop_evt());
		push_event(poll_evt());
		ev = header_evt(HDR_NAME, 0, 5);
		ev.magic = ~cur_magic;
		push_event(ev);
		ev = header_evt(HDR_NAME, 0, 5);
		ev.header_whole = 1'b0;
		push_event(ev);
		push_event(header_evt(HDR_RANGE, 0, 5));
		push_event(data_evt(LEN_W'(7)));
		ev = header_evt(HDR_NAME, 0, 5);
		ev.ack_accepted = 1'b0;
		push_event(ev);
		push_event(poll_evt());
		push_event(header_evt(HDR_NAME, '1, '1));
		push_event(data_evt(LEN_W'(3)));
		ev = header_evt(HDR_RANGE, 0, 4);
		ev.type_code = '1;
		push_event(ev);
		push_event(poll_evt());
		push_event(header_evt(HDR_NAME, 0, 0));
		push_event(header_evt(HDR_RANGE, 5, 9));
		push_event(header_evt(HDR_NAME, 0, 1));
		push_event(header_evt(HDR_RANGE, 0, WORD_W'(BUFFER_BYTES) + 1));
		push_event(header_evt(HDR_NAME, 0, 2));
		push_event(header_evt(HDR_RANGE, 0, WORD_W'(BUFFER_BYTES)));
		push_event(data_evt('0));
		ev = data_evt(BUFFER_BYTES);
		ev.ack_accepted = 1'b0;
		push_event(ev);
		push_event(poll_evt());
		push_event(header_evt(HDR_NAME, 0, 3));
		push_event(header_evt(HDR_RANGE, 0, 10));
		push_event(data_evt(LEN_W'(9)));
		push_event(header_evt(HDR_NAME, 0, 3));
		push_event(header_evt(HDR_RANGE, 0, 10));
		push_event(data_evt(LEN_W'(10)));
		push_event(header_evt(HDR_RANGE, 10, 5));
		push_event(header_evt(HDR_NAME, 0, 3));
		push_event(link_drop_evt());
		push_event(poll_evt());
		push_event(header_evt(HDR_NAME, 0, 3));
		push_event(header_evt(HDR_RANGE, 0, 0));
	endtask

	// One file whose ranges climb to the very top of the 32-bit offset space.
	task automatic run_long_file();
		logic [WORD_W-1:0] pos;
		logic [WORD_W-1:0] len;
		pos = '0;
		push_event(link_drop_evt());
		push_event(poll_evt());
		push_event(header_evt(HDR_NAME, $urandom, $urandom));
		while (pos != '1) begin
			len = ('1 - pos > WORD_W'(BUFFER_BYTES)) ? WORD_W'(BUFFER_BYTES) : '1 - pos;
			push_event(header_evt(HDR_RANGE, pos, pos + len));
			push_event(data_evt(len[LEN_W-1:0]));
			pos = pos + len;
		end
		push_event(header_evt(HDR_RANGE, pos, pos));
	endtask

	// Mostly well-formed push sessions with random content. Any injected fault
	// makes the next session reconnect first so it starts from the name phase.
	task automatic run_sessions(input int unsigned n_events);
		link_evt_t         ev;
		logic [WORD_W-1:0] pos;
		logic [WORD_W-1:0] len;
		int unsigned       stop_at;
		int unsigned       roll;
		logic              synced;
		stop_at = events_sent + n_events;
		synced = 1'b0;
		while (events_sent < stop_at) begin
			if ($urandom_range(0, 99) < 8) begin
				push_event(noise_evt());
				synced = 1'b0;
				continue;
			end
			if (!synced)
				push_event(link_drop_evt());
			push_event(poll_evt());
			synced = 1'b1;
			ev = header_evt(HDR_NAME, $urandom, $urandom);
			if ($urandom_range(0, 99) < 10) begin
				ev = spoil_header(ev);
				synced = 1'b0;
			end
			push_event(ev);
			pos = '0;
			repeat ($urandom_range(0, 4)) begin
				len = pick_len(cur_cap);
				ev = header_evt(HDR_RANGE, pos, pos + len);
				roll = $urandom_range(0, 99);
				if (roll < 11)
					synced = 1'b0;
				if (roll < 6)
					ev = spoil_header(ev);
				else if (roll < 8)
					ev.range_start = pos + $urandom_range(1, 8);
				else if (roll < 10)
					ev.range_end = pos + cur_cap + $urandom_range(1, 8);
				else if (roll < 11)
					ev.range_end = pos - $urandom_range(1, 8);
				push_event(ev);
				if ($urandom_range(0, 99) < 10)
					push_event(stray_evt());
				ev = data_evt(len[LEN_W-1:0]);
				roll = $urandom_range(0, 99);
				if (roll < 10)
					synced = 1'b0;
				if (roll < 5)
					ev.payload_bytes = LEN_W'((len > 1) ? len - 1 : 2);
				else if (roll < 8)
					ev.ack_accepted = 1'b0;
				else if (roll < 10)
					ev.link_up = 1'b0;
				push_event(ev);
				pos = pos + len;
			end
			// Close the file with an empty range most of the time.
			if ($urandom_range(0, 99) < 80) begin
				ev = header_evt(HDR_RANGE, pos, pos);
				if ($urandom_range(0, 99) < 5) begin
					ev = spoil_header(ev);
					synced = 1'b0;
				end
				push_event(ev);
			end else begin
				synced = 1'b0;
			end
		end
	endtask

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		// Smallest chunk limit: every data range is a single byte.
		configure($urandom, 1);
		run_sessions(150);

		// A limit above the buffer size acts as the buffer size.
		configure('1, 32'h01FF_FFFF);
		run_long_file();

		// Output held off while input runs without gaps, then a stretch with random idling again.
		configure('0, $urandom_range(2, 4096));
		gaps_on = 1'b0;
		hold_req = 1'b1;
		run_sessions(150);
		gaps_on = 1'b1;
		run_sessions(90);

		configure($urandom, WORD_W'(BUFFER_BYTES));
		run_sessions(100);

		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("coverage: %0d link events, %0d results, %0d writes, %0d saved, %0d aborted",
			events_sent, n_results, n_writes, n_saves, n_aborts);
		$display("coverage: %0d error steps over %0d register settings", n_errors, settings);
		if (fails == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
